// ===== design/bbs_pkg.sv =====
package bbs_pkg;

   // Register indexes on the write port
   localparam logic [1:0] REG_TIME_STEP = 2'd0;
   localparam logic [1:0] REG_BOLTZMANN = 2'd1;
   localparam logic [1:0] REG_EPSILON   = 2'd2;
   localparam logic [1:0] REG_FLEX_MODE = 2'd3;

   // Result status codes
   localparam logic [2:0] ST_NORMAL    = 3'd0;
   localparam logic [2:0] ST_UNCOUPLED = 3'd1;
   localparam logic [2:0] ST_GUARDED   = 3'd2;
   localparam logic [2:0] ST_CLAMPED   = 3'd3;
   localparam logic [2:0] ST_SATURATED = 3'd4;

   // Reset values of the configuration registers
   localparam logic [23:0] TIME_STEP_RESET = 24'd33554;
   localparam logic [23:0] BOLTZMANN_RESET = 24'd139492;
   localparam logic [23:0] EPSILON_RESET   = 24'd1;

   // Fixed-point constants
   localparam logic [31:0] SCALE_ONE = 32'h4000_0000;
   localparam logic [31:0] SCALE_MAX = 32'hFFFF_FFFF;
   localparam logic [23:0] TEMP_MAX  = 24'hFF_FFFF;
   localparam logic [63:0] ONE_Q60   = 64'h1000_0000_0000_0000;

   // Queue between front and back (power of two)
   localparam int unsigned QUEUE_DEPTH = 4;

   // Pipeline step counts
   localparam int unsigned TEMP_STEPS  = 24;
   localparam int unsigned SCALE_STEPS = 64;
   localparam int unsigned ROOT_STEPS  = 32;

   typedef struct packed {
      logic [23:0] t0;
      logic [23:0] tau;
      logic        imm;
      logic        bypass;
      logic        guard;
   } temp_side_type;

   typedef struct packed {
      logic [39:0]   diff;
      logic [47:0]   dk;
      temp_side_type side;
   } front_item_type;

   typedef struct packed {
      logic [23:0] temp;
      logic        tsat;
      logic        refguard;
      logic        ge;
      logic        imm;
      logic        bypass;
   } scale_side_type;

   typedef struct packed {
      logic [23:0] temp;
      logic        use_root;
      logic [31:0] scale;
      logic [2:0]  status;
   } root_side_type;

endpackage

// ===== design/bbs_front.sv =====
module bbs_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [39:0]              req_kinetic_energy,
   input  logic [39:0]              req_flexible_energy,
   input  logic [23:0]              req_degrees_of_freedom,
   input  logic [23:0]              req_reference_temperature,
   input  logic [23:0]              req_coupling_time,
   input  logic                     req_coupled,
   input  logic                     req_immediate,
   input  logic [23:0]              boltzmann_constant,
   input  logic                     flexible_mode,
   output logic                     item_valid,
   output bbs_pkg::front_item_type  item,
   input  logic                     item_pop
);

   localparam int unsigned PTR_W = $clog2(bbs_pkg::QUEUE_DEPTH);
   localparam logic [PTR_W:0] FULL_COUNT = (PTR_W + 1)'(bbs_pkg::QUEUE_DEPTH);

   logic [39:0]             diff;
   logic                    flex_guard;
   logic [47:0]             dk;
   bbs_pkg::front_item_type entry_in;
   bbs_pkg::front_item_type queue_ff [bbs_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]          count_ff, count_in;
   logic                    accept;
   logic                    pop;

   // Classify the incoming item
   assign dk = req_degrees_of_freedom * boltzmann_constant;

   always_comb begin
      flex_guard = 1'b0;
      diff       = req_kinetic_energy;
      if (flexible_mode) begin
         if (req_flexible_energy >= req_kinetic_energy) begin
            flex_guard = 1'b1;
            diff       = '0;
         end else begin
            diff = req_kinetic_energy - req_flexible_energy;
         end
      end
      entry_in.diff        = diff;
      entry_in.dk          = dk;
      entry_in.side.t0     = req_reference_temperature;
      entry_in.side.tau    = (req_coupling_time == '0) ? 24'd1 : req_coupling_time;
      entry_in.side.imm    = req_immediate;
      entry_in.side.bypass = !req_coupled && !req_immediate;
      entry_in.side.guard  = flex_guard || (diff == '0) || (dk == '0);
   end

   // Queue control
   assign req_stall  = (count_ff == FULL_COUNT);
   assign accept     = req_valid && !req_stall;
   assign item_valid = (count_ff != '0);
   assign pop        = item_pop && item_valid;
   assign item       = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = accept ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (accept && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !accept) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the item
   always_ff @(posedge clock) begin
      if (accept) begin
         queue_ff[wr_ptr_ff] <= entry_in;
      end
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("queue count exceeds depth");

   a_count_push: assert property (@(posedge clock) disable iff (reset)
      (accept && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not advance on push");
`endif

endmodule

// ===== design/bbs_temp_div.sv =====
module bbs_temp_div (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic                    in_valid,
   input  logic [39:0]             in_diff,
   input  logic [47:0]             in_dk,
   input  bbs_pkg::temp_side_type  in_side,
   output logic                    out_valid,
   output logic [23:0]             out_quot,
   output logic                    out_sat,
   output bbs_pkg::temp_side_type  out_side
);

   localparam int unsigned STEPS = bbs_pkg::TEMP_STEPS;

   logic [STEPS:0]         valid_ff;
   logic [47:0]            rem_ff  [STEPS+1];
   logic [47:0]            div_ff  [STEPS+1];
   logic [23:0]            quot_ff [STEPS+1];
   logic                   sat_ff  [STEPS+1];
   bbs_pkg::temp_side_type side_ff [STEPS+1];

   // Advance valid bits with the pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[STEPS-1:0], in_valid};
      end
   end

   // Load: quotient overflows 24 bits when 2*diff >= dk
   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff[0]  <= {7'b0, in_diff, 1'b0};
         div_ff[0]  <= in_dk;
         quot_ff[0] <= '0;
         sat_ff[0]  <= ({8'b0, in_diff} << 1) >= in_dk;
         side_ff[0] <= in_side;
      end
   end

   // One restoring quotient bit per stage
   for (genvar k = 0; k < STEPS; k++) begin : g_step
      logic [48:0] shifted;
      logic [47:0] rem_in;
      logic [23:0] quot_in;

      always_comb begin
         shifted = {rem_ff[k], 1'b0};
         if (shifted >= {1'b0, div_ff[k]}) begin
            rem_in  = 48'(shifted - {1'b0, div_ff[k]});
            quot_in = {quot_ff[k][22:0], 1'b1};
         end else begin
            rem_in  = shifted[47:0];
            quot_in = {quot_ff[k][22:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k+1]  <= rem_in;
            div_ff[k+1]  <= div_ff[k];
            quot_ff[k+1] <= quot_in;
            sat_ff[k+1]  <= sat_ff[k];
            side_ff[k+1] <= side_ff[k];
         end
      end
   end

   assign out_valid = valid_ff[STEPS];
   assign out_quot  = quot_ff[STEPS];
   assign out_sat   = sat_ff[STEPS];
   assign out_side  = side_ff[STEPS];

endmodule

// ===== design/bbs_scale_div.sv =====
module bbs_scale_div (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic                     in_valid,
   input  logic [47:0]              in_num_hi,
   input  logic [11:0]              in_tail,
   input  logic [47:0]              in_div,
   input  bbs_pkg::scale_side_type  in_side,
   output logic                     out_valid,
   output logic [63:0]              out_quot,
   output logic                     out_sat,
   output bbs_pkg::scale_side_type  out_side
);

   localparam int unsigned STEPS = bbs_pkg::SCALE_STEPS;

   logic [STEPS:0]          valid_ff;
   logic [47:0]             rem_ff  [STEPS+1];
   logic [11:0]             tail_ff [STEPS+1];
   logic [47:0]             div_ff  [STEPS+1];
   logic [63:0]             quot_ff [STEPS+1];
   logic                    sat_ff  [STEPS+1];
   bbs_pkg::scale_side_type side_ff [STEPS+1];

   // Advance valid bits with the pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[STEPS-1:0], in_valid};
      end
   end

   // Load: quotient needs more than 64 bits when the high part reaches the divisor
   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff[0]  <= in_num_hi;
         tail_ff[0] <= in_tail;
         div_ff[0]  <= in_div;
         quot_ff[0] <= '0;
         sat_ff[0]  <= in_num_hi >= in_div;
         side_ff[0] <= in_side;
      end
   end

   // One restoring quotient bit per stage, feeding in the dividend tail first
   for (genvar k = 0; k < STEPS; k++) begin : g_step
      logic [48:0] shifted;
      logic [47:0] rem_in;
      logic [63:0] quot_in;

      always_comb begin
         shifted = {rem_ff[k], tail_ff[k][11]};
         if (shifted >= {1'b0, div_ff[k]}) begin
            rem_in  = 48'(shifted - {1'b0, div_ff[k]});
            quot_in = {quot_ff[k][62:0], 1'b1};
         end else begin
            rem_in  = shifted[47:0];
            quot_in = {quot_ff[k][62:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k+1]  <= rem_in;
            tail_ff[k+1] <= {tail_ff[k][10:0], 1'b0};
            div_ff[k+1]  <= div_ff[k];
            quot_ff[k+1] <= quot_in;
            sat_ff[k+1]  <= sat_ff[k];
            side_ff[k+1] <= side_ff[k];
         end
      end
   end

   assign out_valid = valid_ff[STEPS];
   assign out_quot  = quot_ff[STEPS];
   assign out_sat   = sat_ff[STEPS];
   assign out_side  = side_ff[STEPS];

endmodule

// ===== design/bbs_sqrt.sv =====
module bbs_sqrt (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic                    in_valid,
   input  logic [63:0]             in_radicand,
   input  bbs_pkg::root_side_type  in_side,
   output logic                    out_valid,
   output logic [31:0]             out_root,
   output bbs_pkg::root_side_type  out_side
);

   localparam int unsigned STEPS = bbs_pkg::ROOT_STEPS;

   logic [STEPS:0]         valid_ff;
   logic [33:0]            rem_ff  [STEPS+1];
   logic [31:0]            root_ff [STEPS+1];
   logic [63:0]            rad_ff  [STEPS+1];
   bbs_pkg::root_side_type side_ff [STEPS+1];

   // Advance valid bits with the pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[STEPS-1:0], in_valid};
      end
   end

   // Load the radicand
   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff[0]  <= '0;
         root_ff[0] <= '0;
         rad_ff[0]  <= in_radicand;
         side_ff[0] <= in_side;
      end
   end

   // One root bit per stage from the next two radicand bits
   for (genvar k = 0; k < STEPS; k++) begin : g_step
      logic [35:0] cand;
      logic [35:0] trial;
      logic [33:0] rem_in;
      logic [31:0] root_in;

      always_comb begin
         cand  = {rem_ff[k], rad_ff[k][63:62]};
         trial = {2'b00, root_ff[k], 2'b01};
         if (cand >= trial) begin
            rem_in  = 34'(cand - trial);
            root_in = {root_ff[k][30:0], 1'b1};
         end else begin
            rem_in  = cand[33:0];
            root_in = {root_ff[k][30:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k+1]  <= rem_in;
            root_ff[k+1] <= root_in;
            rad_ff[k+1]  <= {rad_ff[k][61:0], 2'b00};
            side_ff[k+1] <= side_ff[k];
         end
      end
   end

   assign out_valid = valid_ff[STEPS];
   assign out_root  = root_ff[STEPS];
   assign out_side  = side_ff[STEPS];

endmodule

// ===== design/berendsen_bath_scale_unit.sv =====
// Throughput: one item per cycle while rsp_stall does not hold a result; the temperature
// divider (24 stages), the scale divider (64 stages) and the square root (32 stages) are
// fully pipelined. A four-entry queue decouples the input from the back pipeline.
// Reset (synchronous, active high) empties the queue and pipeline and loads the
// register defaults.
module berendsen_bath_scale_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [39:0] req_kinetic_energy,
   input  logic [39:0] req_flexible_energy,
   input  logic [23:0] req_degrees_of_freedom,
   input  logic [23:0] req_reference_temperature,
   input  logic [23:0] req_coupling_time,
   input  logic        req_coupled,
   input  logic        req_immediate,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_scale_factor,
   output logic [23:0] rsp_kinetic_temperature,
   output logic [2:0]  rsp_status,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_data
);

   logic [23:0] time_step_ff;
   logic [23:0] boltzmann_ff;
   logic [23:0] epsilon_ff;
   logic        flex_mode_ff;

   logic                    advance;
   logic                    item_valid;
   bbs_pkg::front_item_type item;

   logic                   td_valid;
   logic [23:0]            td_quot;
   logic                   td_sat;
   bbs_pkg::temp_side_type td_side;

   logic [23:0]             t_calc;
   logic                    t_guard;
   bbs_pkg::scale_side_type p1_side_in;
   logic [23:0]             p1_dt_in;

   logic                    p1_valid_ff;
   bbs_pkg::scale_side_type p1_side_ff;
   logic [23:0]             p1_dt_ff;
   logic [23:0]             p1_t0_ff;
   logic [23:0]             p1_tau_ff;

   logic                    p2_valid_ff;
   bbs_pkg::scale_side_type p2_side_ff;
   logic [47:0]             p2_prod_ff;
   logic [47:0]             p2_div_ff;
   logic [23:0]             p2_t0_ff;
   logic [47:0]             sd_num_hi;
   logic [11:0]             sd_tail;

   logic                    sd_valid;
   logic [63:0]             sd_quot;
   logic                    sd_sat;
   bbs_pkg::scale_side_type sd_side;

   logic [63:0]            rad_in;
   bbs_pkg::root_side_type root_side_in;
   logic                   p3_valid_ff;
   logic [63:0]            p3_rad_ff;
   bbs_pkg::root_side_type p3_side_ff;

   logic                   sq_valid;
   logic [31:0]            sq_root;
   bbs_pkg::root_side_type sq_side;

   logic        rsp_valid_ff;
   logic [31:0] rsp_scale_ff;
   logic [23:0] rsp_temp_ff;
   logic [2:0]  rsp_status_ff;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         time_step_ff <= bbs_pkg::TIME_STEP_RESET;
         boltzmann_ff <= bbs_pkg::BOLTZMANN_RESET;
         epsilon_ff   <= bbs_pkg::EPSILON_RESET;
         flex_mode_ff <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            bbs_pkg::REG_TIME_STEP: time_step_ff <= csr_data;
            bbs_pkg::REG_BOLTZMANN: boltzmann_ff <= csr_data;
            bbs_pkg::REG_EPSILON:   epsilon_ff   <= csr_data;
            bbs_pkg::REG_FLEX_MODE: flex_mode_ff <= csr_data[0];
         endcase
      end
   end

   // The whole back pipeline moves unless a finished result is held
   assign advance = !rsp_valid_ff || !rsp_stall;

   bbs_front u_front (
      .clock                     (clock),
      .reset                     (reset),
      .req_valid                 (req_valid),
      .req_stall                 (req_stall),
      .req_kinetic_energy        (req_kinetic_energy),
      .req_flexible_energy       (req_flexible_energy),
      .req_degrees_of_freedom    (req_degrees_of_freedom),
      .req_reference_temperature (req_reference_temperature),
      .req_coupling_time         (req_coupling_time),
      .req_coupled               (req_coupled),
      .req_immediate             (req_immediate),
      .boltzmann_constant        (boltzmann_ff),
      .flexible_mode             (flex_mode_ff),
      .item_valid                (item_valid),
      .item                      (item),
      .item_pop                  (advance)
   );

   bbs_temp_div u_temp_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (item_valid),
      .in_diff   (item.diff),
      .in_dk     (item.dk),
      .in_side   (item.side),
      .out_valid (td_valid),
      .out_quot  (td_quot),
      .out_sat   (td_sat),
      .out_side  (td_side)
   );

   // Apply the temperature guard and form |T0 - T|
   always_comb begin
      t_calc  = td_sat ? bbs_pkg::TEMP_MAX : td_quot;
      t_guard = td_side.guard || (t_calc == '0) || (t_calc < epsilon_ff);
      p1_side_in.temp     = t_guard ? td_side.t0 : t_calc;
      p1_side_in.tsat     = td_sat && !t_guard;
      p1_side_in.refguard = (p1_side_in.temp == '0) || (p1_side_in.temp < epsilon_ff);
      p1_side_in.ge       = td_side.t0 >= p1_side_in.temp;
      p1_side_in.imm      = td_side.imm;
      p1_side_in.bypass   = td_side.bypass;
      p1_dt_in = p1_side_in.ge ? td_side.t0 - p1_side_in.temp
                               : p1_side_in.temp - td_side.t0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
         p3_valid_ff <= 1'b0;
      end else if (advance) begin
         p1_valid_ff <= td_valid;
         p2_valid_ff <= p1_valid_ff;
         p3_valid_ff <= sd_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p1_side_ff <= p1_side_in;
         p1_dt_ff   <= p1_dt_in;
         p1_t0_ff   <= td_side.t0;
         p1_tau_ff  <= td_side.tau;
      end
   end

   // Form dt*|T0-T| and the divisor
   always_ff @(posedge clock) begin
      if (advance) begin
         p2_side_ff <= p1_side_ff;
         p2_prod_ff <= time_step_ff * p1_dt_ff;
         p2_div_ff  <= p1_side_ff.imm ? {24'b0, p1_side_ff.temp}
                                      : p1_tau_ff * p1_side_ff.temp;
         p2_t0_ff   <= p1_t0_ff;
      end
   end

   // Immediate divides T0*2^60, relaxed divides dt*|T0-T|*2^52
   assign sd_num_hi = p2_side_ff.imm ? {28'b0, p2_t0_ff[23:4]} : {12'b0, p2_prod_ff[47:12]};
   assign sd_tail   = p2_side_ff.imm ? {p2_t0_ff[3:0], 8'b0} : p2_prod_ff[11:0];

   bbs_scale_div u_scale_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (p2_valid_ff),
      .in_num_hi (sd_num_hi),
      .in_tail   (sd_tail),
      .in_div    (p2_div_ff),
      .in_side   (p2_side_ff),
      .out_valid (sd_valid),
      .out_quot  (sd_quot),
      .out_sat   (sd_sat),
      .out_side  (sd_side)
   );

   // Pick the radicand or settle the result without a root
   always_comb begin
      rad_in                = sd_quot;
      root_side_in.temp     = sd_side.temp;
      root_side_in.use_root = 1'b1;
      root_side_in.scale    = '0;
      root_side_in.status   = sd_side.tsat ? bbs_pkg::ST_SATURATED : bbs_pkg::ST_NORMAL;
      if (sd_side.bypass) begin
         root_side_in.temp     = '0;
         root_side_in.use_root = 1'b0;
         root_side_in.scale    = bbs_pkg::SCALE_ONE;
         root_side_in.status   = bbs_pkg::ST_UNCOUPLED;
      end else if (sd_side.refguard) begin
         root_side_in.use_root = 1'b0;
         root_side_in.scale    = bbs_pkg::SCALE_ONE;
         root_side_in.status   = bbs_pkg::ST_GUARDED;
      end else if (sd_side.imm) begin
         if (sd_sat) begin
            root_side_in.use_root = 1'b0;
            root_side_in.scale    = bbs_pkg::SCALE_MAX;
            root_side_in.status   = bbs_pkg::ST_SATURATED;
         end
      end else if (sd_side.ge) begin
         if (sd_sat || (sd_quot[63:60] == 4'hF)) begin
            root_side_in.use_root = 1'b0;
            root_side_in.scale    = bbs_pkg::SCALE_MAX;
            root_side_in.status   = bbs_pkg::ST_SATURATED;
         end else begin
            rad_in = sd_quot + bbs_pkg::ONE_Q60;
         end
      end else begin
         if (sd_sat || (sd_quot > bbs_pkg::ONE_Q60)) begin
            root_side_in.use_root = 1'b0;
            root_side_in.scale    = '0;
            root_side_in.status   = bbs_pkg::ST_CLAMPED;
         end else begin
            rad_in = bbs_pkg::ONE_Q60 - sd_quot;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p3_rad_ff  <= rad_in;
         p3_side_ff <= root_side_in;
      end
   end

   bbs_sqrt u_sqrt (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .in_valid    (p3_valid_ff),
      .in_radicand (p3_rad_ff),
      .in_side     (p3_side_ff),
      .out_valid   (sq_valid),
      .out_root    (sq_root),
      .out_side    (sq_side)
   );

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= sq_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && sq_valid) begin
         rsp_scale_ff  <= sq_side.use_root ? sq_root : sq_side.scale;
         rsp_temp_ff   <= sq_side.temp;
         rsp_status_ff <= sq_side.status;
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_scale_factor        = rsp_scale_ff;
   assign rsp_kinetic_temperature = rsp_temp_ff;
   assign rsp_status              = rsp_status_ff;

`ifndef ASSERT_OFF
   a_uncoupled_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == bbs_pkg::ST_UNCOUPLED)) |->
      ((rsp_scale_factor == bbs_pkg::SCALE_ONE) && (rsp_kinetic_temperature == '0)))
      else $error("uncoupled result not unit scale");

   a_clamped_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == bbs_pkg::ST_CLAMPED)) |-> (rsp_scale_factor == '0))
      else $error("clamped result has nonzero scale");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status <= bbs_pkg::ST_SATURATED))
      else $error("status code out of range");
`endif

endmodule
